// ===== src/uer_pkg.sv =====
package uer_pkg;

    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 32;
    localparam int TRIG_LEN_W  = 8;
    localparam int TIMEOUT_W   = 16;
    localparam int INTERVAL_W  = 24;
    localparam int DURATION_W  = 16;
    localparam int DISTANCE_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [TRIG_LEN_W-1:0] TRIG_LEN_RESET     = 8'd10;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET      = 16'd32000;
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = 24'd1000000;

    localparam logic [CFG_INDEX_W-1:0] REG_TRIG_LEN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL = 2'd2;

    // Division by 58 is a multiply by ceil(2^22 / 58) and a shift by 22,
    // exact for every 16-bit duration.
    localparam int              DIV_RECIP_W = 17;
    localparam int              DIV_SHIFT   = 22;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 17'd72316;
    localparam int              DIV_PROD_W  = DURATION_W + DIV_RECIP_W;

    typedef enum logic [3:0]
    {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_RISE = 4'b0100,
        PH_HIGH = 4'b1000
    } phase_t;

endpackage

// ===== src/ultrasonic_echo_ranger.sv =====
// Ultrasonic ranger controller that takes one request per microsecond tick on the
// input stream and returns exactly one result per request on the output stream. The
// controller state and the result register both load on the clock edge that accepts
// the request, so a new request can be taken every cycle. The only throughput limit
// is back-pressure from the output side. The conversion from duration to centimeters
// is one 16 by 17 bit multiply by the reciprocal of 58; it feeds the result register
// directly. Configuration writes are accepted on every cycle and take effect from the
// next request onward.
module ultrasonic_echo_ranger
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0 up: echo_level, start_request, zero padding.
    input  logic [uer_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0 up: trigger_level, busy_res, done_res, refused,
    // measure_status, duration_us, distance_cm.
    output logic [uer_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [uer_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [uer_pkg::TRIG_LEN_W-1:0]  trig_len_reg;
    logic [uer_pkg::TIMEOUT_W-1:0]   timeout_reg;
    logic [uer_pkg::INTERVAL_W-1:0]  min_interval_reg;

    uer_pkg::phase_t                 phase_reg, phase_next;
    logic [uer_pkg::TIMEOUT_W-1:0]   phase_count_reg, phase_count_next;
    logic [uer_pkg::INTERVAL_W-1:0]  interval_count_reg, interval_count_next;
    logic                            interval_running_reg, interval_running_next;
    logic [uer_pkg::DURATION_W-1:0]  last_duration_reg, last_duration_next;
    logic [uer_pkg::DISTANCE_W-1:0]  last_distance_reg, last_distance_next;
    logic                            last_status_reg, last_status_next;

    logic                            out_valid_reg;
    logic [uer_pkg::OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic                            echo;
    logic                            start;
    logic                            trig;
    logic                            done;
    logic                            refused;
    logic                            busy;
    logic                            in_accept;
    logic [uer_pkg::INTERVAL_W:0]    interval_inc;
    logic [uer_pkg::TIMEOUT_W:0]     count_inc;
    logic [uer_pkg::TIMEOUT_W:0]     limit;
    logic [uer_pkg::DIV_PROD_W-1:0]  div_prod;
    logic [uer_pkg::DISTANCE_W-1:0]  quotient;

    assign echo          = s_axis_tdata[0];
    assign start         = s_axis_tdata[1];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    assign interval_inc = {1'b0, interval_count_reg} + 25'd1;
    assign count_inc    = {1'b0, phase_count_reg} + 17'd1;
    assign limit        = (timeout_reg == '0) ? 17'd1 : {1'b0, timeout_reg};
    assign div_prod     = uer_pkg::DIV_PROD_W'(phase_count_reg)
                          * uer_pkg::DIV_PROD_W'(uer_pkg::DIV_RECIP);
    assign quotient     = div_prod[uer_pkg::DIV_SHIFT +: uer_pkg::DISTANCE_W];

    always_comb
    begin
        phase_next            = phase_reg;
        phase_count_next      = phase_count_reg;
        interval_count_next   = interval_count_reg;
        interval_running_next = interval_running_reg;
        last_duration_next    = last_duration_reg;
        last_distance_next    = last_distance_reg;
        last_status_next      = last_status_reg;
        trig                  = 1'b0;
        done                  = 1'b0;
        refused               = 1'b0;

        if (interval_running_reg)
        begin
            interval_count_next = interval_inc[uer_pkg::INTERVAL_W-1:0];
            if (interval_inc >= {1'b0, min_interval_reg})
            begin
                interval_running_next = 1'b0;
            end
        end

        unique case (phase_reg)
            uer_pkg::PH_IDLE:
            begin
                if (start)
                begin
                    if (interval_running_next)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        interval_count_next   = '0;
                        interval_running_next = 1'b1;
                        trig                  = 1'b1;
                        if (trig_len_reg <= 8'd1)
                        begin
                            phase_next       = uer_pkg::PH_RISE;
                            phase_count_next = '0;
                        end
                        else
                        begin
                            phase_next       = uer_pkg::PH_TRIG;
                            phase_count_next = 16'd1;
                        end
                    end
                end
            end
            uer_pkg::PH_TRIG:
            begin
                refused = start;
                trig    = 1'b1;
                if (count_inc >= {9'b0, trig_len_reg})
                begin
                    phase_next       = uer_pkg::PH_RISE;
                    phase_count_next = '0;
                end
                else
                begin
                    phase_count_next = count_inc[uer_pkg::TIMEOUT_W-1:0];
                end
            end
            uer_pkg::PH_RISE:
            begin
                refused = start;
                if ((echo && (limit <= 17'd1)) || (!echo && (count_inc >= limit)))
                begin
                    last_status_next = 1'b1;
                    phase_next       = uer_pkg::PH_IDLE;
                    phase_count_next = '0;
                    done             = 1'b1;
                end
                else if (echo)
                begin
                    phase_next       = uer_pkg::PH_HIGH;
                    phase_count_next = 16'd1;
                end
                else
                begin
                    phase_count_next = count_inc[uer_pkg::TIMEOUT_W-1:0];
                end
            end
            uer_pkg::PH_HIGH:
            begin
                refused = start;
                if (echo)
                begin
                    if (count_inc >= limit)
                    begin
                        last_status_next = 1'b1;
                        phase_next       = uer_pkg::PH_IDLE;
                        phase_count_next = '0;
                        done             = 1'b1;
                    end
                    else
                    begin
                        phase_count_next = count_inc[uer_pkg::TIMEOUT_W-1:0];
                    end
                end
                else
                begin
                    last_duration_next = phase_count_reg;
                    last_distance_next = quotient;
                    last_status_next   = 1'b0;
                    phase_next         = uer_pkg::PH_IDLE;
                    phase_count_next   = '0;
                    done               = 1'b1;
                end
            end
            default:
            begin
                phase_next       = uer_pkg::PH_IDLE;
                phase_count_next = '0;
            end
        endcase

        busy          = (phase_next != uer_pkg::PH_IDLE);
        out_data_next = {last_distance_next, last_duration_next, last_status_next,
                         refused, done, busy, trig};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_len_reg     <= uer_pkg::TRIG_LEN_RESET;
            timeout_reg      <= uer_pkg::TIMEOUT_RESET;
            min_interval_reg <= uer_pkg::MIN_INTERVAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                uer_pkg::REG_TRIG_LEN:
                begin
                    trig_len_reg <= cfg_data[uer_pkg::TRIG_LEN_W-1:0];
                end
                uer_pkg::REG_TIMEOUT:
                begin
                    timeout_reg <= cfg_data[uer_pkg::TIMEOUT_W-1:0];
                end
                uer_pkg::REG_MIN_INTERVAL:
                begin
                    min_interval_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= uer_pkg::PH_IDLE;
            phase_count_reg      <= '0;
            interval_count_reg   <= '0;
            interval_running_reg <= 1'b0;
            last_duration_reg    <= '0;
            last_distance_reg    <= '0;
            last_status_reg      <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg            <= phase_next;
            phase_count_reg      <= phase_count_next;
            interval_count_reg   <= interval_count_next;
            interval_running_reg <= interval_running_next;
            last_duration_reg    <= last_duration_next;
            last_distance_reg    <= last_distance_next;
            last_status_reg      <= last_status_next;
            out_valid_reg        <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
